@@ hdl/euler_to_rotation_matrix_defines.svh @@
// Assertion macros shared by the Euler-angle rotation matrix RTL.
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define E2R_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("e2r: implication check failed");
// Next-cycle implication, sampled on clk, off while rst is high.
`define E2R_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2r: next-cycle check failed");
`else
`define E2R_ASSERT_IMP(name, ante, cons)
`define E2R_ASSERT_NXT(name, ante, cons)
`endif
`endif

@@ hdl/e2r_pkg.sv @@
// Types, constants and sign-magnitude helpers for the Euler-angle rotation matrix.
package e2r_pkg;

  // Pipeline layout: sine/cosine stages first, then the matrix stages.
  localparam int SIN_STAGES = 7;
  localparam int NSTG       = 14;
  localparam int ST_PROD1   = 7;
  localparam int ST_PROD2   = 8;
  localparam int ST_TERMS   = 9;
  localparam int ST_SUM     = 10;
  localparam int ST_ABS     = 11;
  localparam int ST_ROUND   = 12;
  localparam int ST_OUT     = 13;

  // Datapath widths.
  localparam int MAG_SM_W = 32;  // magnitude of a Q30 value
  localparam int TERM_W   = 34;  // one product term, two's complement
  localparam int SUM_W    = 35;  // sum of two terms
  localparam int MAG_W    = 36;  // magnitude through rounding and scaling

  // Quarter-wave sine polynomial, Q30.
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] C9      = 31'd172272;
  localparam logic [30:0] SINE_COEF [4] = '{
    31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  localparam logic [63:0] ROUND_Q30 = 64'h2000_0000;

  // Row-major index of the transposed entry.
  localparam int TR_IDX [9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

  typedef struct packed {
    logic                neg;
    logic [MAG_SM_W-1:0] mag;
  } sm_t;

  localparam sm_t SM_ZERO = '{neg: 1'b0, mag: '0};

  // Q30 product, rounded half away from zero on the magnitude.
  function automatic sm_t sm_mul(sm_t a, sm_t b);
    logic [63:0] p;
    sm_t         r;
    p     = 64'(a.mag) * 64'(b.mag) + ROUND_Q30;
    r.neg = a.neg ^ b.neg;
    r.mag = MAG_SM_W'(p >> 30);
    return r;
  endfunction

  function automatic sm_t sm_flip(sm_t a);
    sm_t r;
    r.neg = ~a.neg;
    r.mag = a.mag;
    return r;
  endfunction

  function automatic logic signed [TERM_W-1:0] sm_to_tc(sm_t a);
    logic signed [TERM_W-1:0] m;
    m = signed'(TERM_W'(a.mag));
    return a.neg ? -m : m;
  endfunction

endpackage

@@ hdl/e2r_angle_if.sv @@
// Input channel: one word of roll, pitch and yaw binary angles.
interface e2r_angle_if #(
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                  input ready);
  modport sink (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                output ready);
endinterface

@@ hdl/e2r_matrix_if.sv @@
// Output channel: one word of nine Q1.(ENTRY_BITS-1) matrix entries.
interface e2r_matrix_if #(
  parameter int ENTRY_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ENTRY_BITS-1:0] m00;
  logic signed [ENTRY_BITS-1:0] m01;
  logic signed [ENTRY_BITS-1:0] m02;
  logic signed [ENTRY_BITS-1:0] m10;
  logic signed [ENTRY_BITS-1:0] m11;
  logic signed [ENTRY_BITS-1:0] m12;
  logic signed [ENTRY_BITS-1:0] m20;
  logic signed [ENTRY_BITS-1:0] m21;
  logic signed [ENTRY_BITS-1:0] m22;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  input ready);
  modport sink (input valid, input m00, input m01, input m02, input m10,
                input m11, input m12, input m20, input m21, input m22,
                output ready);
endinterface

@@ hdl/e2r_sine_pipe.sv @@
// Seven-stage sine (or cosine) of a binary angle by quarter-wave polynomial.
module e2r_sine_pipe #(
  parameter int ANGLE_BITS = 16,
  parameter bit COSINE     = 1'b0
) (
  input  logic                            clk,
  input  logic [e2r_pkg::SIN_STAGES-1:0] en,
  input  logic [ANGLE_BITS-1:0]           angle,
  output e2r_pkg::sm_t                    sine
);
  import e2r_pkg::*;

  localparam int PAD = 32 - ANGLE_BITS;

  logic [1:0]            quad;
  logic [29:0]           frac;
  logic [30:0]           t_in;
  logic [30:0]           t_q   [SIN_STAGES-1];
  logic [30:0]           sq_q  [1:SIN_STAGES-3];
  logic [30:0]           r_q   [2:SIN_STAGES-2];
  logic [SIN_STAGES-1:0] neg_q;
  logic [MAG_SM_W-1:0]   mag_q;

  // Cosine is the sine one quadrant on.
  always_comb begin
    quad = angle[ANGLE_BITS-1 -: 2] + 2'(COSINE);
    frac = {angle[ANGLE_BITS-3:0], PAD'(0)};
    t_in = quad[0] ? (Q30_ONE - {1'b0, frac}) : {1'b0, frac};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_q[0]   <= t_in;
      neg_q[0] <= quad[1];
    end
    for (int s = 1; s < SIN_STAGES; s++) begin
      if (en[s]) neg_q[s] <= neg_q[s-1];
    end
    for (int s = 1; s < SIN_STAGES - 1; s++) begin
      if (en[s]) t_q[s] <= t_q[s-1];
    end
    if (en[1]) sq_q[1] <= 31'((62'(t_q[0]) * 62'(t_q[0])) >> 30);
    for (int s = 2; s < SIN_STAGES - 2; s++) begin
      if (en[s]) sq_q[s] <= sq_q[s-1];
    end
    // Horner steps, one multiply per stage
    if (en[2]) r_q[2] <= SINE_COEF[0] - 31'((62'(sq_q[1]) * 62'(C9)) >> 30);
    for (int s = 3; s < SIN_STAGES - 1; s++) begin
      if (en[s]) begin
        r_q[s] <= SINE_COEF[s-2] - 31'((62'(sq_q[s-1]) * 62'(r_q[s-1])) >> 30);
      end
    end
    if (en[SIN_STAGES-1]) begin
      mag_q <= MAG_SM_W'((62'(t_q[SIN_STAGES-2]) * 62'(r_q[SIN_STAGES-2])) >> 30);
    end
  end

  always_comb begin
    sine.neg = neg_q[SIN_STAGES-1];
    sine.mag = mag_q;
  end

endmodule

@@ hdl/euler_to_rotation_matrix.sv @@
// Top level: roll/pitch/yaw to direction cosine matrix, fourteen-stage pipeline.
//
// Channels: angles (sink) takes one word of roll, pitch and yaw binary angles;
// matrix (source) gives one word of nine entries m00..m22, row-major, Q1.15 by
// default. A word moves on a rising edge with valid and ready both high.
// cfg_wr_en/cfg_wr_data write inverse_mode: 0 gives the body-to-earth matrix,
// 1 its transpose (earth-to-body). Write it only while the pipeline is empty.
//
// Pipeline: an accepted angle word passes the seven-stage sine polynomial, two
// multiply levels, the term sum and the rounding and saturation stages to its
// matrix word. Throughput: one word per cycle while the receiver takes words.
//
// Each stage carries a valid bit and moves on whenever it, or the stage after
// it, is empty, so bubbles close up. When the receiver stalls, the last stage
// holds its word and the stages behind it fill; angles.ready drops only once
// every stage holds a word. Nothing is lost or repeated.
//
// Reset (rst, synchronous): empties the pipeline and clears inverse_mode.
`include "euler_to_rotation_matrix_defines.svh"

module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int ENTRY_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  e2r_angle_if.sink    angles,
  e2r_matrix_if.source matrix
);
  import e2r_pkg::*;

  localparam int SHIFT = (ENTRY_BITS <= 31) ? 31 - ENTRY_BITS : 0;
  localparam int LSH   = (ENTRY_BITS > 31) ? ENTRY_BITS - 31 : 0;
  localparam logic [MAG_W-1:0] HALF = (MAG_W'(1) << SHIFT) >> 1;
  localparam logic signed [ENTRY_BITS-1:0] POS_MAX = {1'b0, {(ENTRY_BITS-1){1'b1}}};
  localparam logic signed [ENTRY_BITS-1:0] NEG_MIN = {1'b1, {(ENTRY_BITS-1){1'b0}}};
  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(POS_MAX);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (ENTRY_BITS - 1);

  logic            inverse_mode;
  logic [NSTG-1:0] valid;
  logic [NSTG-1:0] en;

  sm_t s_roll, c_roll, s_pitch, c_pitch, s_yaw, c_yaw;

  // first product level
  sm_t cpst_q, spst_q, sf7_q, cf7_q, st7_q;
  sm_t p00_q, p10_q, spcf_q, spsf_q, cpcf_q, cpsf_q, p21_q, p22_q;
  // second product level
  sm_t a_q, b_q, c_q, d_q, st8_q;
  sm_t p00b_q, p10b_q, spcfb_q, spsfb_q, cpcfb_q, cpsfb_q, p21b_q, p22b_q;

  sm_t tx [9];
  sm_t ty [9];

  logic signed [TERM_W-1:0]     term_x_q [9];
  logic signed [TERM_W-1:0]     term_y_q [9];
  logic signed [SUM_W-1:0]      sum_q    [9];
  logic [8:0]                   neg_abs_q;
  logic [MAG_W-1:0]             mag_abs_q [9];
  logic [8:0]                   neg_rnd_q;
  logic [MAG_W-1:0]             rnd_q    [9];
  logic signed [ENTRY_BITS-1:0] ent_next [9];
  logic signed [ENTRY_BITS-1:0] ent_q    [9];

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      inverse_mode <= cfg_wr_data;
    end
  end

  // Stage enables: advance a stage when it is empty or its successor advances.
  for (genvar s = 0; s < NSTG - 1; s++) begin : g_en
    assign en[s] = !valid[s] || en[s+1];
  end
  assign en[NSTG-1] = !valid[NSTG-1] || matrix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= angles.valid;
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) valid[s] <= valid[s-1];
      end
    end
  end

  assign angles.ready = en[0];
  assign matrix.valid = valid[NSTG-1];

  // Six sine/cosine pipes
  e2r_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COSINE(1'b0)) u_sin_roll (
    .clk(clk), .en(en[SIN_STAGES-1:0]),
    .angle(angles.roll_angle[ANGLE_BITS-1:0]), .sine(s_roll));
  e2r_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COSINE(1'b1)) u_cos_roll (
    .clk(clk), .en(en[SIN_STAGES-1:0]),
    .angle(angles.roll_angle[ANGLE_BITS-1:0]), .sine(c_roll));
  e2r_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COSINE(1'b0)) u_sin_pitch (
    .clk(clk), .en(en[SIN_STAGES-1:0]),
    .angle(angles.pitch_angle[ANGLE_BITS-1:0]), .sine(s_pitch));
  e2r_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COSINE(1'b1)) u_cos_pitch (
    .clk(clk), .en(en[SIN_STAGES-1:0]),
    .angle(angles.pitch_angle[ANGLE_BITS-1:0]), .sine(c_pitch));
  e2r_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COSINE(1'b0)) u_sin_yaw (
    .clk(clk), .en(en[SIN_STAGES-1:0]),
    .angle(angles.yaw_angle[ANGLE_BITS-1:0]), .sine(s_yaw));
  e2r_sine_pipe #(.ANGLE_BITS(ANGLE_BITS), .COSINE(1'b1)) u_cos_yaw (
    .clk(clk), .en(en[SIN_STAGES-1:0]),
    .angle(angles.yaw_angle[ANGLE_BITS-1:0]), .sine(c_yaw));

  // Terms of the swapped matrix: row 0 is M row 2, row 1 is minus M row 1,
  // row 2 is M row 0. Single-product entries take a zero second term.
  always_comb begin
    tx[0] = sm_flip(st8_q);   ty[0] = SM_ZERO;
    tx[1] = p21b_q;           ty[1] = SM_ZERO;
    tx[2] = p22b_q;           ty[2] = SM_ZERO;
    tx[3] = sm_flip(p10b_q);  ty[3] = SM_ZERO;
    tx[4] = sm_flip(c_q);     ty[4] = sm_flip(cpcfb_q);
    tx[5] = sm_flip(d_q);     ty[5] = cpsfb_q;
    tx[6] = p00b_q;           ty[6] = SM_ZERO;
    tx[7] = a_q;              ty[7] = sm_flip(spcfb_q);
    tx[8] = b_q;              ty[8] = spsfb_q;
  end

  // Saturate to the entry range, then restore the sign.
  always_comb begin
    for (int e = 0; e < 9; e++) begin
      if (!neg_rnd_q[e] && rnd_q[e] > POS_LIM) begin
        ent_next[e] = POS_MAX;
      end else if (neg_rnd_q[e] && rnd_q[e] > NEG_LIM) begin
        ent_next[e] = NEG_MIN;
      end else if (neg_rnd_q[e]) begin
        ent_next[e] = ENTRY_BITS'(-rnd_q[e]);
      end else begin
        ent_next[e] = ENTRY_BITS'(rnd_q[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PROD1]) begin
      cpst_q <= sm_mul(c_yaw, s_pitch);
      spst_q <= sm_mul(s_yaw, s_pitch);
      p00_q  <= sm_mul(c_yaw, c_pitch);
      p10_q  <= sm_mul(s_yaw, c_pitch);
      spcf_q <= sm_mul(s_yaw, c_roll);
      spsf_q <= sm_mul(s_yaw, s_roll);
      cpcf_q <= sm_mul(c_yaw, c_roll);
      cpsf_q <= sm_mul(c_yaw, s_roll);
      p21_q  <= sm_mul(c_pitch, s_roll);
      p22_q  <= sm_mul(c_pitch, c_roll);
      sf7_q  <= s_roll;
      cf7_q  <= c_roll;
      st7_q  <= s_pitch;
    end
    if (en[ST_PROD2]) begin
      a_q     <= sm_mul(cpst_q, sf7_q);
      b_q     <= sm_mul(cpst_q, cf7_q);
      c_q     <= sm_mul(spst_q, sf7_q);
      d_q     <= sm_mul(spst_q, cf7_q);
      st8_q   <= st7_q;
      p00b_q  <= p00_q;
      p10b_q  <= p10_q;
      spcfb_q <= spcf_q;
      spsfb_q <= spsf_q;
      cpcfb_q <= cpcf_q;
      cpsfb_q <= cpsf_q;
      p21b_q  <= p21_q;
      p22b_q  <= p22_q;
    end
    for (int e = 0; e < 9; e++) begin
      if (en[ST_TERMS]) begin
        term_x_q[e] <= sm_to_tc(tx[e]);
        term_y_q[e] <= sm_to_tc(ty[e]);
      end
      if (en[ST_SUM]) begin
        if (inverse_mode) begin
          sum_q[e] <= SUM_W'(term_x_q[TR_IDX[e]]) + SUM_W'(term_y_q[TR_IDX[e]]);
        end else begin
          sum_q[e] <= SUM_W'(term_x_q[e]) + SUM_W'(term_y_q[e]);
        end
      end
      if (en[ST_ABS]) begin
        neg_abs_q[e] <= sum_q[e][SUM_W-1];
        mag_abs_q[e] <= MAG_W'(sum_q[e][SUM_W-1] ? -sum_q[e] : sum_q[e]);
      end
      if (en[ST_ROUND]) begin
        neg_rnd_q[e] <= neg_abs_q[e];
        rnd_q[e]     <= ((mag_abs_q[e] + HALF) >> SHIFT) << LSH;
      end
      if (en[ST_OUT]) begin
        ent_q[e] <= ent_next[e];
      end
    end
  end

  assign matrix.m00 = ent_q[0];
  assign matrix.m01 = ent_q[1];
  assign matrix.m02 = ent_q[2];
  assign matrix.m10 = ent_q[3];
  assign matrix.m11 = ent_q[4];
  assign matrix.m12 = ent_q[5];
  assign matrix.m20 = ent_q[6];
  assign matrix.m21 = ent_q[7];
  assign matrix.m22 = ent_q[8];

  // Refuse input only with every stage full.
  `E2R_ASSERT_IMP(a_refuse_only_full, !angles.ready, &valid)
  // An accepted word lands in the first stage.
  `E2R_ASSERT_NXT(a_take_fills_head, angles.valid && angles.ready, valid[0])
  // A full pipeline under stall keeps every word.
  `E2R_ASSERT_NXT(a_full_stall_holds, (&valid) && !matrix.ready, &valid)
  // A delivered word with a bubble behind it leaves the output empty.
  `E2R_ASSERT_NXT(a_bubble_follows,
                  matrix.valid && matrix.ready && !valid[NSTG-2], !matrix.valid)

endmodule
